[design/ba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_pkg
// Shared types, status codes and default sizes of the buddy allocator.
// ----------------------------------------------------------------------------
package ba_pkg;

	localparam int DEF_NUM_ORDERS      = 8;
	localparam int DEF_MIN_BLOCK_SHIFT = 4;
	localparam int DEF_STACK_DEPTH     = 128;

	localparam logic       KIND_ALLOC = 1'b0;
	localparam logic       KIND_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOMEM   = 2'd1;
	localparam logic [1:0] STATUS_BADADDR = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [11:0] request_size;
		logic [11:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] granted_offset;
	} rsp_t;

endpackage

[design/ba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ba_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/buddy_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_allocator_top
// Buddy allocator with per-order free and busy stacks held in one RAM.
// ----------------------------------------------------------------------------
// Pulse start with a request while busy is low; busy then stays high until the
// response, unless the request is refused at once. The response appears on rsp
// for exactly one cycle with done high, and the receiver cannot stall it, so
// capture it on that cycle. A request's length varies, set by the single RAM
// port pair that holds every stack: an allocate scans each empty order, then
// pops a block and writes both halves of each split; a free compares busy
// entries one at a time (lowest order, bottom entry first), moves each later
// entry one slot down when an entry is removed, and searches likewise for each
// buddy while merging. No clearing pass is needed after reset: the one block
// free at reset is supplied by a flag until its stack slot is first written.
// ----------------------------------------------------------------------------
module buddy_allocator_top
	import ba_pkg::*;
#(
	parameter int NUM_ORDERS      = DEF_NUM_ORDERS,
	parameter int MIN_BLOCK_SHIFT = DEF_MIN_BLOCK_SHIFT,
	parameter int STACK_DEPTH     = DEF_STACK_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int OW     = $clog2(NUM_ORDERS);
	localparam int IW     = $clog2(STACK_DEPTH);
	localparam int CW     = $clog2(STACK_DEPTH + 1);
	localparam int OFF_W  = MIN_BLOCK_SHIFT + NUM_ORDERS - 1;
	localparam int AW     = 1 + OW + IW;
	localparam int POOL   = 1 << OFF_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam logic [OW-1:0] TOP_ORD = OW'(NUM_ORDERS - 1);
	localparam logic SEL_FREE = 1'b0;
	localparam logic SEL_BUSY = 1'b1;
	// slot that holds the whole pool at reset
	localparam logic [AW-1:0] TOP_SLOT0 = {SEL_FREE, TOP_ORD, IW'(0)};

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_A_SCAN = 9'b000000010,
		S_A_LO   = 9'b000000100,
		S_A_HI   = 9'b000001000,
		S_A_GNT  = 9'b000010000,
		S_S_RD   = 9'b000100000,
		S_S_CMP  = 9'b001000000,
		S_D_RD   = 9'b010000000,
		S_D_WR   = 9'b100000000
	} state_t;

	state_t          state_q, state_d;
	logic [OW-1:0]   ord_q, ord_d, lvl_q, lvl_d;
	logic            sel_q, sel_d;
	logic [OFF_W-1:0] off_q, off_d, base_q, base_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   fcnt_q [NUM_ORDERS];
	logic [CW-1:0]   fcnt_d [NUM_ORDERS];
	logic [CW-1:0]   bcnt_q [NUM_ORDERS];
	logic [CW-1:0]   bcnt_d [NUM_ORDERS];
	logic            top_init_q, rd_init_s1;
	logic            done_q, done_d;
	rsp_t            rsp_q, rsp_d;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [OFF_W-1:0] ram_wdata, ram_rdata, rd;

	logic [31:0]     size_ext, off_ext, gnt_ext;
	logic [OW-1:0]   aord, lvl_m1, lvl_p1;
	logic            afound;
	logic [OFF_W-1:0] bsz, bsz_lo, key;
	logic [CW-1:0]   cnt_cur, cnt_m1, idx_m1;

	ba_ram #(.AW(AW), .DW(OFF_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// the reset block reads as offset zero until its slot is written
	assign rd = rd_init_s1 ? '0 : ram_rdata;

	// smallest order that holds the requested size
	always_comb begin
		size_ext = {20'b0, req.request_size};
		aord     = '0;
		afound   = 1'b0;
		for (int o = 0; o < NUM_ORDERS; o++) begin
			if (!afound && ((32'(1) << (MIN_BLOCK_SHIFT + o)) >= size_ext)) begin
				aord   = OW'(o);
				afound = 1'b1;
			end
		end
	end

	assign off_ext = {20'b0, req.block_offset};
	assign lvl_m1  = lvl_q - 1'b1;
	assign lvl_p1  = lvl_q + 1'b1;
	assign bsz     = OFF_W'(32'(1) << (MIN_BLOCK_SHIFT + 32'(lvl_q)));
	assign bsz_lo  = OFF_W'(32'(1) << (MIN_BLOCK_SHIFT + 32'(lvl_m1)));
	assign cnt_cur = (sel_q == SEL_BUSY) ? bcnt_q[lvl_q] : fcnt_q[lvl_q];
	assign cnt_m1  = fcnt_q[lvl_q] - 1'b1;
	assign idx_m1  = idx_q - 1'b1;
	// busy search looks for the offset itself, merge search for its buddy
	assign key     = (sel_q == SEL_BUSY) ? off_q : (off_q ^ bsz);
	assign gnt_ext = 32'(rd);

	always_comb begin
		state_d   = state_q;
		ord_d     = ord_q;
		lvl_d     = lvl_q;
		sel_d     = sel_q;
		off_d     = off_q;
		base_d    = base_q;
		idx_d     = idx_q;
		fcnt_d    = fcnt_q;
		bcnt_d    = bcnt_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.kind == KIND_ALLOC) begin
						if (!afound || bcnt_q[aord] >= DEPTH_C) begin
							done_d  = 1'b1;
							rsp_d   = '{status: STATUS_NOMEM, granted_offset: '0};
						end else begin
							ord_d   = aord;
							lvl_d   = aord;
							state_d = S_A_SCAN;
						end
					end else begin
						if (off_ext >= 32'(POOL)) begin
							done_d  = 1'b1;
							rsp_d   = '{status: STATUS_BADADDR, granted_offset: '0};
						end else begin
							off_d   = off_ext[OFF_W-1:0];
							lvl_d   = '0;
							idx_d   = '0;
							sel_d   = SEL_BUSY;
							state_d = S_S_RD;
						end
					end
				end
			end
			S_A_SCAN: begin
				// walk up to the first non-empty order, then pop its top
				if (fcnt_q[lvl_q] == '0) begin
					if (lvl_q == TOP_ORD) begin
						done_d  = 1'b1;
						rsp_d   = '{status: STATUS_NOMEM, granted_offset: '0};
						state_d = S_IDLE;
					end else begin
						lvl_d   = lvl_p1;
					end
				end else begin
					ram_re         = 1'b1;
					ram_raddr      = {SEL_FREE, lvl_q, cnt_m1[IW-1:0]};
					fcnt_d[lvl_q]  = cnt_m1;
					state_d        = (lvl_q == ord_q) ? S_A_GNT : S_A_LO;
				end
			end
			S_A_LO: begin
				base_d = rd;
				if (fcnt_q[lvl_m1] < DEPTH_C) begin
					ram_we         = 1'b1;
					ram_waddr      = {SEL_FREE, lvl_m1, fcnt_q[lvl_m1][IW-1:0]};
					ram_wdata      = rd;
					fcnt_d[lvl_m1] = fcnt_q[lvl_m1] + 1'b1;
				end
				state_d = S_A_HI;
			end
			S_A_HI: begin
				if (fcnt_q[lvl_m1] < DEPTH_C) begin
					ram_we         = 1'b1;
					ram_waddr      = {SEL_FREE, lvl_m1, fcnt_q[lvl_m1][IW-1:0]};
					ram_wdata      = base_q + bsz_lo;
					fcnt_d[lvl_m1] = fcnt_q[lvl_m1] + 1'b1;
				end
				lvl_d   = lvl_m1;
				state_d = S_A_SCAN;
			end
			S_A_GNT: begin
				ram_we        = 1'b1;
				ram_waddr     = {SEL_BUSY, ord_q, bcnt_q[ord_q][IW-1:0]};
				ram_wdata     = rd;
				bcnt_d[ord_q] = bcnt_q[ord_q] + 1'b1;
				done_d        = 1'b1;
				rsp_d         = '{status: STATUS_OK, granted_offset: gnt_ext[10:0]};
				state_d       = S_IDLE;
			end
			S_S_RD: begin
				if (idx_q < cnt_cur) begin
					ram_re    = 1'b1;
					ram_raddr = {sel_q, lvl_q, idx_q[IW-1:0]};
					state_d   = S_S_CMP;
				end else if (sel_q == SEL_BUSY) begin
					// not at this order: try the next one
					if (lvl_q == TOP_ORD) begin
						done_d  = 1'b1;
						rsp_d   = '{status: STATUS_BADADDR, granted_offset: '0};
						state_d = S_IDLE;
					end else begin
						lvl_d = lvl_p1;
						idx_d = '0;
					end
				end else begin
					// buddy not free: settle the block at this order
					if (fcnt_q[lvl_q] < DEPTH_C) begin
						ram_we        = 1'b1;
						ram_waddr     = {SEL_FREE, lvl_q, fcnt_q[lvl_q][IW-1:0]};
						ram_wdata     = off_q;
						fcnt_d[lvl_q] = fcnt_q[lvl_q] + 1'b1;
					end
					done_d  = 1'b1;
					rsp_d   = '{status: STATUS_OK, granted_offset: '0};
					state_d = S_IDLE;
				end
			end
			S_S_CMP: begin
				if (rd == key) begin
					idx_d   = idx_q + 1'b1;
					state_d = S_D_RD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_S_RD;
				end
			end
			S_D_RD: begin
				if (idx_q < cnt_cur) begin
					ram_re    = 1'b1;
					ram_raddr = {sel_q, lvl_q, idx_q[IW-1:0]};
					state_d   = S_D_WR;
				end else begin
					// entry removed; advance the merge
					if (sel_q == SEL_BUSY) begin
						bcnt_d[lvl_q] = bcnt_q[lvl_q] - 1'b1;
					end else begin
						fcnt_d[lvl_q] = fcnt_q[lvl_q] - 1'b1;
						off_d         = off_q & ~bsz;
						lvl_d         = lvl_p1;
					end
					if (lvl_d == TOP_ORD) begin
						if (fcnt_q[TOP_ORD] < DEPTH_C) begin
							ram_we          = 1'b1;
							ram_waddr       = {SEL_FREE, TOP_ORD, fcnt_q[TOP_ORD][IW-1:0]};
							ram_wdata       = off_d;
							fcnt_d[TOP_ORD] = fcnt_q[TOP_ORD] + 1'b1;
						end
						done_d  = 1'b1;
						rsp_d   = '{status: STATUS_OK, granted_offset: '0};
						state_d = S_IDLE;
					end else begin
						sel_d   = SEL_FREE;
						idx_d   = '0;
						state_d = S_S_RD;
					end
				end
			end
			S_D_WR: begin
				// move the entry one slot down
				ram_we    = 1'b1;
				ram_waddr = {sel_q, lvl_q, idx_m1[IW-1:0]};
				ram_wdata = rd;
				idx_d     = idx_q + 1'b1;
				state_d   = S_D_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			top_init_q <= 1'b1;
			rd_init_s1 <= 1'b0;
			done_q     <= 1'b0;
			for (int o = 0; o < NUM_ORDERS; o++) begin
				fcnt_q[o] <= (o == NUM_ORDERS - 1) ? CW'(1) : '0;
				bcnt_q[o] <= '0;
			end
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			fcnt_q     <= fcnt_d;
			bcnt_q     <= bcnt_d;
			if (ram_re) begin
				rd_init_s1 <= top_init_q && (ram_raddr == TOP_SLOT0);
			end
			if (ram_we && ram_waddr == TOP_SLOT0) begin
				top_init_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ord_q  <= ord_d;
		lvl_q  <= lvl_d;
		sel_q  <= sel_d;
		off_q  <= off_d;
		base_q <= base_d;
		idx_q  <= idx_d;
		rsp_q  <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
